>>> sv/sbcp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the segment to box closest point block.
package sbcp_pkg;

  // Segment parameter t is unsigned Q1.TIME_BITS, running from 0 to 1.
  localparam int TIME_BITS = 32;
  localparam logic [TIME_BITS:0] TIME_ONE = {1'b1, {TIME_BITS{1'b0}}};

  // Digit width of the shared multiplier, one digit per cycle.
  localparam int DIGIT_BITS = 16;

  // Most slab crossings walked before the result is taken.
  localparam int MAX_PASSES = 7;

  // Position of one axis relative to its slab.
  typedef logic [1:0] region_t;
  localparam region_t REG_IN    = 2'd0;
  localparam region_t REG_BELOW = 2'd1;
  localparam region_t REG_ABOVE = 2'd2;

endpackage

>>> sv/sbcp_mul.sv
`timescale 1ns / 1ps
// Digit-serial unsigned multiplier shared by all products of the block.
module sbcp_mul #(
  parameter int A_W = 33,
  parameter int B_W = 35
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [A_W-1:0]       a_i,
  input  logic [B_W-1:0]       b_i,
  output logic                 done_o,
  output logic [A_W+B_W-1:0]   p_o
);

  localparam int D     = sbcp_pkg::DIGIT_BITS;
  localparam int STEPS = (B_W + D - 1) / D;
  localparam int BP    = STEPS * D;
  localparam int AP    = A_W + BP;
  localparam int CW    = $clog2(STEPS + 1);

  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [A_W-1:0]   a_q;
  logic [BP-1:0]    b_q;
  logic [AP-1:0]    acc_q;
  logic [A_W+D-1:0] pp;

  // One digit row: the full product of the operand and the top digit.
  assign pp = a_q * b_q[BP-1 -: D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Most significant digit first: shift the partial sum, add one digit row.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BP'(b_i);
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q << D) + AP'(pp);
      b_q   <= b_q << D;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q[A_W+B_W-1:0];

endmodule

>>> sv/sbcp_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider that yields TIME_BITS quotient bits, one per cycle.
module sbcp_div #(
  parameter int W = 71
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [W-1:0]                   num_i,
  input  logic [W-1:0]                   den_i,
  output logic                           done_o,
  output logic [sbcp_pkg::TIME_BITS-1:0] q_o,
  output logic                           rem_nz_o
);

  localparam int TB = sbcp_pkg::TIME_BITS;
  localparam int CW = $clog2(TB + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [W-1:0]  r_q;
  logic [W-1:0]  m_q;
  logic [TB-1:0] q_q;
  logic [W:0]    r2;
  logic [W:0]    rd;
  logic          ge;

  // The numerator is always below the divisor, so the shifted remainder fits W+1.
  always_comb begin
    r2 = {r_q, 1'b0};
    ge = (r2 >= {1'b0, m_q});
    rd = ge ? (r2 - {1'b0, m_q}) : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(TB);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= num_i;
      m_q <= den_i;
      q_q <= '0;
    end else if (cnt_q != '0) begin
      r_q <= rd[W-1:0];
      q_q <= {q_q[TB-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign q_o      = q_q;
  assign rem_nz_o = |r_q;

endmodule

>>> sv/segment_box_closest_point_top.sv
`timescale 1ns / 1ps
// Top level of the segment to box closest point block: sequencer and axis datapath.
//
// Usage: a transaction is offered by raising start with the box corners and the
// segment end points on the input ports; it is taken at the clock edge where
// start is high and busy is low. busy then stays high until the result leaves.
// The closest box point appears on near_x_o, near_y_o and near_z_o for exactly
// one cycle, marked by done_o; busy falls in that same cycle, so a new
// transaction may be started while done_o is high. The receiver cannot stall:
// it must take the result in the cycle done_o is high.
// One multiplier and one divider are shared by all three axes. The setup takes up
// to 3 divisions; then follow up to eight slope evaluations, up to three slab
// re-entries with one division each, at most one final division and the output
// pass, which takes one product per axis. One transaction is in work at a time.
// Reset returns the sequencer to idle and drops done_o; no result in flight
// survives it.
module segment_box_closest_point_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] box_min_x_i,
  input  logic signed [COORD_BITS-1:0] box_min_y_i,
  input  logic signed [COORD_BITS-1:0] box_min_z_i,
  input  logic signed [COORD_BITS-1:0] box_max_x_i,
  input  logic signed [COORD_BITS-1:0] box_max_y_i,
  input  logic signed [COORD_BITS-1:0] box_max_z_i,
  input  logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_start_z_i,
  input  logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_end_y_i,
  input  logic signed [COORD_BITS-1:0] seg_end_z_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] near_x_o,
  output logic signed [COORD_BITS-1:0] near_y_o,
  output logic signed [COORD_BITS-1:0] near_z_o
);

  localparam int CB  = COORD_BITS;
  localparam int TB  = sbcp_pkg::TIME_BITS;
  localparam int TW  = TB + 1;                    // time, 0 .. 1 inclusive
  localparam int CW  = CB + 1;                    // center sum and half size
  localparam int SW  = CB + 2;                    // doubled start offset
  localparam int PW  = CB + 4;                    // positions and distances
  localparam int VW  = CB + 1;                    // mirrored direction
  localparam int MBW = (CB + 3 > TW) ? CB + 3 : TW;
  localparam int MPW = VW + MBW;
  localparam int GW  = 2 * CB + 7;                // slope and squared-length sums

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_INIT_DIV = 4'd2;
  localparam logic [3:0] S_SL_AX    = 4'd3;
  localparam logic [3:0] S_SL_POS   = 4'd4;
  localparam logic [3:0] S_SL_PRD   = 4'd5;
  localparam logic [3:0] S_SL_END   = 4'd6;
  localparam logic [3:0] S_PASS     = 4'd7;
  localparam logic [3:0] S_UPD      = 4'd8;
  localparam logic [3:0] S_UPD_DIV  = 4'd9;
  localparam logic [3:0] S_MSUM     = 4'd10;
  localparam logic [3:0] S_MSUM_W   = 4'd11;
  localparam logic [3:0] S_QDIV     = 4'd12;
  localparam logic [3:0] S_QWAIT    = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;
  localparam logic [3:0] S_OUT_W    = 4'd15;

  // Which caller a slope evaluation returns to.
  localparam logic CTX_START = 1'b0;
  localparam logic CTX_PASS  = 1'b1;

  localparam logic [1:0] AX_LAST = 2'd2;
  localparam logic [2:0] PASS_LAST = 3'(sbcp_pkg::MAX_PASSES - 1);

  // Control registers.
  logic [3:0] st_q, st_d;
  logic [1:0] ax_q, ax_d;
  logic [2:0] pass_q, pass_d;
  logic       ctx_q, ctx_d;
  logic       done_q, done_d;

  // Captured transaction, one entry per axis.
  logic signed [CB-1:0] lo_q [3];
  logic signed [CB-1:0] hi_q [3];
  logic signed [CB-1:0] sa_q [3];
  logic signed [CB-1:0] sb_q [3];

  // Per-axis walk state, in doubled units around the box center.
  logic signed [SW-1:0]     s_q    [3];
  logic signed [CW-1:0]     h_q    [3];
  logic        [VW-1:0]     v_q    [3];
  logic signed [CW-1:0]     c2_q   [3];
  logic                     flip_q [3];
  sbcp_pkg::region_t        rg_q   [3];
  logic        [TW-1:0]     ta_q   [3];
  logic signed [CB-1:0]     out_q  [3];

  logic        [TW-1:0]     t_q;
  logic        [TW-1:0]     nt_q;
  logic signed [GW-1:0]     g_q;
  logic signed [GW-1:0]     acc_q;
  logic                     eneg_q;

  // Shared units.
  logic                     mul_go;
  logic [MBW-1:0]           mul_b;
  logic                     mul_done;
  logic [MPW-1:0]           mul_p;
  logic                     div_go;
  logic [GW-1:0]            div_n;
  logic [GW-1:0]            div_m;
  logic                     div_done;
  logic [TB-1:0]            div_q;
  logic                     div_rnz;

  // Current axis view.
  logic signed [SW-1:0]     cur_s;
  logic signed [CW-1:0]     cur_h;
  logic        [VW-1:0]     cur_v;
  logic signed [CW-1:0]     cur_c2;
  logic                     cur_flip;
  sbcp_pkg::region_t        cur_rg;
  logic        [TW-1:0]     cur_ta;
  logic                     last_ax;

  // Setup arithmetic of the current axis.
  logic signed [CB-1:0]     in_lo, in_hi, in_a, in_b;
  logic signed [CW-1:0]     c2_c, h_c;
  logic signed [SW-1:0]     s0_c, dv_c, s_c, dvm_c;
  logic                     flip_c;
  logic        [VW-1:0]     v_c;
  sbcp_pkg::region_t        rg_c;
  logic signed [PW-1:0]     n_c;
  logic                     need_c;
  logic signed [PW-1:0]     sp_c, hp_c, vp_c;

  // Walk arithmetic of the current axis.
  logic signed [PW-1:0]     sp, hp, vp;
  logic        [VW-1:0]     dmul;
  logic signed [PW-1:0]     pos, bnd, e_c, emag, n_up, tmp, clmp, o2, res;
  logic                     upd_div;
  logic        [TW-1:0]     ct;
  logic        [TW-1:0]     nt_c;
  logic        [TW-1:0]     span;
  logic        [GW-1:0]     r_u, m_u;
  logic        [TW-1:0]     q_ext;
  logic signed [GW-1:0]     pe;
  logic                     acc_neg;

  assign cur_s    = s_q[ax_q];
  assign cur_h    = h_q[ax_q];
  assign cur_v    = v_q[ax_q];
  assign cur_c2   = c2_q[ax_q];
  assign cur_flip = flip_q[ax_q];
  assign cur_rg   = rg_q[ax_q];
  assign cur_ta   = ta_q[ax_q];
  assign last_ax  = (ax_q == AX_LAST);
  assign acc_neg  = acc_q[GW-1];

  // Setup: shift into doubled units around the center, mirror so the
  // direction is non-negative, then class the start against the slab.
  always_comb begin
    in_lo  = lo_q[ax_q];
    in_hi  = hi_q[ax_q];
    in_a   = sa_q[ax_q];
    in_b   = sb_q[ax_q];
    c2_c   = CW'(in_lo) + CW'(in_hi);
    h_c    = CW'(in_hi) - CW'(in_lo);
    s0_c   = (SW'(in_a) <<< 1) - SW'(c2_c);
    dv_c   = (SW'(in_b) - SW'(in_a)) <<< 1;
    flip_c = dv_c[SW-1];
    s_c    = flip_c ? -s0_c : s0_c;
    dvm_c  = flip_c ? -dv_c : dv_c;
    v_c    = dvm_c[VW-1:0];
    sp_c   = PW'(s_c);
    hp_c   = PW'(h_c);
    vp_c   = $signed(PW'(v_c));
    rg_c   = sbcp_pkg::REG_IN;
    n_c    = '0;
    if (v_c != '0) begin
      if (sp_c < -hp_c) begin
        rg_c = sbcp_pkg::REG_BELOW;
        n_c  = -hp_c - sp_c;
      end else if (sp_c >= hp_c) begin
        rg_c = sbcp_pkg::REG_ABOVE;
      end else begin
        n_c  = hp_c - sp_c;
      end
    end
    // A crossing exists only when the distance is positive and below one step.
    need_c = (v_c != '0) && (rg_c != sbcp_pkg::REG_ABOVE) &&
             (n_c > PW'(0)) && (n_c < vp_c);
  end

  // Walk: position at the time last multiplied, distance to the active face,
  // exit distance for re-entry, and the clamped output.
  always_comb begin
    sp    = PW'(cur_s);
    hp    = PW'(cur_h);
    vp    = $signed(PW'(cur_v));
    dmul  = mul_p[TB +: VW];
    pos   = sp + $signed(PW'(dmul));
    bnd   = (cur_rg == sbcp_pkg::REG_BELOW) ? -hp : hp;
    e_c   = pos - bnd;
    emag  = e_c[PW-1] ? -e_c : e_c;
    n_up  = hp - sp;
    upd_div = (cur_rg == sbcp_pkg::REG_BELOW) && (n_up > PW'(0)) && (n_up < vp);
    ct    = TW'(div_q) + TW'(div_rnz);
    tmp   = cur_flip ? -pos : pos;
    if (tmp < -hp) begin
      clmp = -hp;
    end else if (tmp > hp) begin
      clmp = hp;
    end else begin
      clmp = tmp;
    end
    o2    = clmp + PW'(cur_c2) + PW'(1);
    res   = o2 >>> 1;
    pe    = $signed(GW'(mul_p));
    span  = nt_q - t_q;
    r_u   = $unsigned(-g_q);
    m_u   = $unsigned(acc_q);
    q_ext = TW'(div_q);
  end

  // Earliest pending crossing after the current time.
  always_comb begin
    nt_c = sbcp_pkg::TIME_ONE;
    for (int i = 0; i < 3; i++) begin
      if ((ta_q[i] > t_q) && (ta_q[i] < sbcp_pkg::TIME_ONE) && (ta_q[i] < nt_c)) begin
        nt_c = ta_q[i];
      end
    end
  end

  // Sequencer.
  always_comb begin
    st_d   = st_q;
    ax_d   = ax_q;
    pass_d = pass_q;
    ctx_d  = ctx_q;
    done_d = 1'b0;
    mul_go = 1'b0;
    mul_b  = '0;
    div_go = 1'b0;
    div_n  = '0;
    div_m  = '0;
    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          st_d = S_INIT;
          ax_d = '0;
        end
      end
      S_INIT, S_INIT_DIV: begin
        if (st_q == S_INIT && need_c) begin
          div_go = 1'b1;
          div_n  = GW'(n_c[VW-1:0]);
          div_m  = GW'(v_c);
          st_d   = S_INIT_DIV;
        end else if (st_q == S_INIT || div_done) begin
          if (last_ax) begin
            st_d  = S_SL_AX;
            ax_d  = '0;
            ctx_d = CTX_START;
          end else begin
            st_d = S_INIT;
            ax_d = ax_q + 2'd1;
          end
        end
      end
      S_SL_AX, S_SL_PRD: begin
        if (st_q == S_SL_AX && cur_rg != sbcp_pkg::REG_IN) begin
          mul_go = 1'b1;
          mul_b  = MBW'(nt_q);
          st_d   = S_SL_POS;
        end else if (st_q == S_SL_AX || mul_done) begin
          if (last_ax) begin
            st_d = S_SL_END;
            ax_d = '0;
          end else begin
            st_d = S_SL_AX;
            ax_d = ax_q + 2'd1;
          end
        end
      end
      S_SL_POS: begin
        if (mul_done) begin
          mul_go = 1'b1;
          mul_b  = MBW'(emag[PW-2:0]);
          st_d   = S_SL_PRD;
        end
      end
      S_SL_END: begin
        ax_d = '0;
        if (ctx_q == CTX_START) begin
          if (acc_neg) begin
            st_d   = S_PASS;
            pass_d = '0;
          end else begin
            st_d = S_OUT;
          end
        end else if (!acc_neg) begin
          st_d = S_MSUM;
        end else if (nt_q == sbcp_pkg::TIME_ONE) begin
          st_d = S_OUT;
        end else begin
          st_d = S_UPD;
        end
      end
      S_PASS: begin
        st_d  = S_SL_AX;
        ax_d  = '0;
        ctx_d = CTX_PASS;
      end
      S_UPD, S_UPD_DIV: begin
        if (st_q == S_UPD && cur_ta == nt_q && upd_div) begin
          div_go = 1'b1;
          div_n  = GW'(n_up[VW-1:0]);
          div_m  = GW'(cur_v);
          st_d   = S_UPD_DIV;
        end else if (st_q == S_UPD || div_done) begin
          if (!last_ax) begin
            st_d = S_UPD;
            ax_d = ax_q + 2'd1;
          end else if (pass_q == PASS_LAST) begin
            st_d = S_OUT;
            ax_d = '0;
          end else begin
            st_d   = S_PASS;
            pass_d = pass_q + 3'd1;
          end
        end
      end
      S_MSUM, S_MSUM_W: begin
        if (st_q == S_MSUM && cur_rg != sbcp_pkg::REG_IN) begin
          mul_go = 1'b1;
          mul_b  = MBW'(cur_v);
          st_d   = S_MSUM_W;
        end else if (st_q == S_MSUM || mul_done) begin
          if (last_ax) begin
            st_d = S_QDIV;
            ax_d = '0;
          end else begin
            st_d = S_MSUM;
            ax_d = ax_q + 2'd1;
          end
        end
      end
      S_QDIV: begin
        if (m_u == '0 || r_u >= m_u) begin
          st_d = S_OUT;
        end else begin
          div_go = 1'b1;
          div_n  = r_u;
          div_m  = m_u;
          st_d   = S_QWAIT;
        end
      end
      S_QWAIT: begin
        if (div_done) begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        mul_go = 1'b1;
        mul_b  = MBW'(t_q);
        st_d   = S_OUT_W;
      end
      S_OUT_W: begin
        if (mul_done) begin
          if (last_ax) begin
            st_d   = S_IDLE;
            done_d = 1'b1;
          end else begin
            st_d = S_OUT;
            ax_d = ax_q + 2'd1;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ax_q   <= '0;
      pass_q <= '0;
      ctx_q  <= CTX_START;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ax_q   <= ax_d;
      pass_q <= pass_d;
      ctx_q  <= ctx_d;
      done_q <= done_d;
    end
  end

  // Datapath registers follow the sequencer; none of them needs a reset.
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (start) begin
          lo_q[0] <= box_min_x_i;   lo_q[1] <= box_min_y_i;   lo_q[2] <= box_min_z_i;
          hi_q[0] <= box_max_x_i;   hi_q[1] <= box_max_y_i;   hi_q[2] <= box_max_z_i;
          sa_q[0] <= seg_start_x_i; sa_q[1] <= seg_start_y_i; sa_q[2] <= seg_start_z_i;
          sb_q[0] <= seg_end_x_i;   sb_q[1] <= seg_end_y_i;   sb_q[2] <= seg_end_z_i;
          t_q     <= '0;
          nt_q    <= '0;
          acc_q   <= '0;
        end
      end
      S_INIT: begin
        s_q[ax_q]    <= s_c;
        h_q[ax_q]    <= h_c;
        v_q[ax_q]    <= v_c;
        c2_q[ax_q]   <= c2_c;
        flip_q[ax_q] <= flip_c;
        rg_q[ax_q]   <= rg_c;
        ta_q[ax_q]   <= sbcp_pkg::TIME_ONE;
      end
      S_INIT_DIV: begin
        if (div_done) begin
          ta_q[ax_q] <= ct;
        end
      end
      S_SL_POS: begin
        if (mul_done) begin
          eneg_q <= e_c[PW-1];
        end
      end
      S_SL_PRD, S_MSUM_W: begin
        if (mul_done) begin
          acc_q <= (st_q == S_SL_PRD && eneg_q) ? acc_q - pe : acc_q + pe;
        end
      end
      S_SL_END: begin
        if (ctx_q == CTX_START || acc_neg) begin
          g_q <= acc_q;
        end
        if (ctx_q == CTX_PASS && acc_neg && nt_q == sbcp_pkg::TIME_ONE) begin
          t_q <= sbcp_pkg::TIME_ONE;
        end
        acc_q <= '0;
      end
      S_PASS: begin
        nt_q  <= nt_c;
        acc_q <= '0;
      end
      S_UPD: begin
        if (cur_ta == nt_q && !upd_div) begin
          // An entry from below with no later exit goes inside; an exit, or an entry into a too thin slab, goes above.
          if (cur_rg == sbcp_pkg::REG_BELOW && n_up > PW'(0)) begin
            rg_q[ax_q] <= sbcp_pkg::REG_IN;
          end else begin
            rg_q[ax_q] <= sbcp_pkg::REG_ABOVE;
          end
          ta_q[ax_q] <= sbcp_pkg::TIME_ONE;
        end
        if (last_ax && !(cur_ta == nt_q && upd_div)) begin
          t_q <= nt_q;
        end
      end
      S_UPD_DIV: begin
        if (div_done) begin
          // A thin slab is left at the same instant it is entered.
          if (ct <= nt_q) begin
            rg_q[ax_q] <= sbcp_pkg::REG_ABOVE;
            ta_q[ax_q] <= sbcp_pkg::TIME_ONE;
          end else begin
            rg_q[ax_q] <= sbcp_pkg::REG_IN;
            ta_q[ax_q] <= ct;
          end
          if (last_ax) begin
            t_q <= nt_q;
          end
        end
      end
      S_QDIV: begin
        if (m_u != '0 && r_u >= m_u) begin
          t_q <= nt_q;
        end
      end
      S_QWAIT: begin
        if (div_done) begin
          t_q <= t_q + ((q_ext < span) ? q_ext : span);
        end
      end
      S_OUT_W: begin
        if (mul_done) begin
          out_q[ax_q] <= res[CB-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  sbcp_mul #(
    .A_W (VW),
    .B_W (MBW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (cur_v),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  sbcp_div #(
    .W (GW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_go),
    .num_i    (div_n),
    .den_i    (div_m),
    .done_o   (div_done),
    .q_o      (div_q),
    .rem_nz_o (div_rnz)
  );

  assign busy     = (st_q != S_IDLE);
  assign done_o   = done_q;
  assign near_x_o = out_q[0];
  assign near_y_o = out_q[1];
  assign near_z_o = out_q[2];

endmodule

>>> sv/sbcp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the segment to box closest point block, with its bind.
module sbcp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // An accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after a transaction was accepted");

  // The result strobe comes only as the block goes idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe without a finishing transaction");

  // Busy never ends without a result.
  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("transaction ended without a result");

  // One result per transaction: the strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

endmodule

bind segment_box_closest_point_top sbcp_checker u_sbcp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

>>> test/tb_segment_box_closest_point_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the segment to box closest point block.
module tb_segment_box_closest_point_top;

  // One transaction: index 0..2 box min, 3..5 box max, 6..8 start, 9..11 end.
  typedef logic [11:0][31:0] query_t;
  typedef logic [2:0][31:0] point_t;
  typedef logic signed [127:0] wide_t;
  typedef struct {
    query_t q;
    bit     drain;
  } job_t;

  localparam wide_t T_ONE = wide_t'(1) <<< sbcp_pkg::TIME_BITS;

  logic clk_i = 1'b1;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done_o;
  logic signed [31:0] near_x_o, near_y_o, near_z_o;
  query_t cur = '0;

  job_t   jobs[$];
  point_t nearest_q[$];
  int     errors = 0;
  int     issued = 0;
  bit     taken = 1'b0;

  // Per-axis state of the slab walk, in doubled units about the box center.
  wide_t             lane_ctr[3], lane_half[3], lane_rate[3], lane_cross[3];
  sbcp_pkg::region_t lane_side[3];

  segment_box_closest_point_top #(.COORD_BITS(32)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .box_min_x_i(cur[0]), .box_min_y_i(cur[1]), .box_min_z_i(cur[2]),
    .box_max_x_i(cur[3]), .box_max_y_i(cur[4]), .box_max_z_i(cur[5]),
    .seg_start_x_i(cur[6]), .seg_start_y_i(cur[7]), .seg_start_z_i(cur[8]),
    .seg_end_x_i(cur[9]), .seg_end_y_i(cur[10]), .seg_end_z_i(cur[11]),
    .done_o(done_o), .near_x_o(near_x_o), .near_y_o(near_y_o), .near_z_o(near_z_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Point of the segment at time t: center offset plus floor(t * rate).
  function automatic wide_t place(wide_t s, wide_t v, wide_t t);
    return s + ((t * v) >>> sbcp_pkg::TIME_BITS);
  endfunction

  // Time at which distance n is covered at rate v, rounded up on the time grid.
  function automatic wide_t crossing(wide_t n, wide_t v);
    if (n <= 0 || n >= v) return T_ONE;
    return ((n <<< sbcp_pkg::TIME_BITS) + v - 1) / v;
  endfunction

  // Slope of the squared distance at time t over the axes that lie outside.
  function automatic wide_t slope(wide_t t);
    wide_t g, bnd;
    g = 0;
    for (int i = 0; i < 3; i++) begin
      if (lane_side[i] != sbcp_pkg::REG_IN) begin
        bnd = (lane_side[i] == sbcp_pkg::REG_BELOW) ? -lane_half[i] : lane_half[i];
        g += lane_rate[i] * (place(lane_ctr[i], lane_rate[i], t) - bnd);
      end
    end
    return g;
  endfunction

  function automatic point_t closest_point(query_t f);
    wide_t  lo, hi, a, b, dv, t, g, ng, nt, m, q, span, p;
    wide_t  c2[3];
    bit     flip[3];
    point_t res;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      lo = $signed(f[i]);
      hi = $signed(f[3+i]);
      a = $signed(f[6+i]);
      b = $signed(f[9+i]);
      c2[i] = lo + hi;
      lane_half[i] = hi - lo;
      lane_ctr[i] = 2 * a - c2[i];
      dv = 2 * (b - a);
      flip[i] = dv < 0;
      if (flip[i]) begin
        lane_ctr[i] = -lane_ctr[i];
        dv = -dv;
      end
      lane_rate[i] = dv;
      lane_side[i] = sbcp_pkg::REG_IN;
      lane_cross[i] = T_ONE;
      if (dv > 0) begin
        if (lane_ctr[i] < -lane_half[i]) begin
          lane_side[i] = sbcp_pkg::REG_BELOW;
          lane_cross[i] = crossing(-lane_half[i] - lane_ctr[i], dv);
        end else if (lane_ctr[i] >= lane_half[i]) begin
          lane_side[i] = sbcp_pkg::REG_ABOVE;
        end else begin
          lane_cross[i] = crossing(lane_half[i] - lane_ctr[i], dv);
        end
      end
    end

    g = slope(0);
    if (g < 0) begin
      for (int pass = 0; pass < sbcp_pkg::MAX_PASSES; pass++) begin
        nt = T_ONE;
        for (int i = 0; i < 3; i++)
          if (lane_cross[i] > t && lane_cross[i] < T_ONE && lane_cross[i] < nt)
            nt = lane_cross[i];
        ng = slope(nt);
        if (ng >= 0) begin
          // The slope turns positive inside this span: interpolate its zero.
          m = 0;
          span = nt - t;
          for (int i = 0; i < 3; i++)
            if (lane_side[i] != sbcp_pkg::REG_IN) m += lane_rate[i] * lane_rate[i];
          if (m == 0) q = 0;
          else if (-g >= m) q = span;
          else q = ((-g) <<< sbcp_pkg::TIME_BITS) / m;
          t += (q < span) ? q : span;
          break;
        end
        if (nt < T_ONE) begin
          for (int i = 0; i < 3; i++) begin
            if (lane_cross[i] == nt) begin
              if (lane_side[i] == sbcp_pkg::REG_BELOW) begin
                lane_side[i] = sbcp_pkg::REG_IN;
                lane_cross[i] = crossing(lane_half[i] - lane_ctr[i], lane_rate[i]);
                // A slab too thin to stay inside sends the axis straight above.
                if (lane_half[i] - lane_ctr[i] <= 0 || lane_cross[i] <= nt) begin
                  lane_side[i] = sbcp_pkg::REG_ABOVE;
                  lane_cross[i] = T_ONE;
                end
              end else begin
                lane_side[i] = sbcp_pkg::REG_ABOVE;
                lane_cross[i] = T_ONE;
              end
            end
          end
        end
        t = nt;
        g = ng;
        if (t >= T_ONE) begin
          t = T_ONE;
          break;
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      p = place(lane_ctr[i], lane_rate[i], t);
      if (flip[i]) p = -p;
      if (p < -lane_half[i]) p = -lane_half[i];
      else if (p > lane_half[i]) p = lane_half[i];
      res[i] = 32'((p + c2[i] + 1) >>> 1);
    end
    return res;
  endfunction

  function automatic logic [31:0] sat(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  task automatic add(input int c[12], input bit drain = 1'b0);
    job_t j;
    for (int i = 0; i < 12; i++) j.q[i] = c[i];
    j.drain = drain;
    jobs.push_back(j);
  endtask

  // Random query: mostly a box with a segment passing around it at some scale.
  task automatic add_random(input bit drain);
    job_t   j;
    longint span, ctr, hs, lo, hi, a;
    int     pick;
    pick = $urandom_range(0, 99);
    j.drain = drain;
    if (pick < 10) begin
      for (int i = 0; i < 12; i++) j.q[i] = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: span = 256;
        1: span = 65536;
        2: span = 1 << 20;
        default: span = 1 << 29;
      endcase
      for (int i = 0; i < 3; i++) begin
        ctr = spread(span);
        hs = (pick % 7 == 0 && i == 0) ? 0 : longint'($urandom_range(0, 32'(span)));
        lo = ctr - hs;
        hi = ctr + hs;
        if ($urandom_range(0, 19) == 0) begin
          a = lo;
          lo = hi;
          hi = a;
        end
        j.q[i] = sat(lo);
        j.q[3+i] = sat(hi);
        a = ctr + 3 * spread(span);
        if ($urandom_range(0, 19) == 0) a = hi;
        j.q[6+i] = sat(a);
        j.q[9+i] = ($urandom_range(0, 9) == 0) ? sat(a) : sat(ctr + 3 * spread(span));
      end
    end
    jobs.push_back(j);
  endtask

  // Driver: offers queued transactions at the falling edge, holding each one
  // until the block takes it. A job flagged for draining waits until every
  // expected result has come back. Idling is skipped over a quiet stretch.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (jobs.size() > 0 &&
                 ((issued >= 600 && issued < 900) || $urandom_range(0, 99) >= 10) &&
                 !(jobs[0].drain && nearest_q.size() > 0)) begin
      cur <= jobs[0].q;
      start <= 1'b1;
      void'(jobs.pop_front());
      issued++;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predicts each accepted transaction and checks each result.
  always @(posedge clk_i) begin
    point_t want;
    point_t got;
    taken = rst_ni && start && !busy;
    if (taken) nearest_q.push_back(closest_point(cur));
    if (rst_ni && done_o) begin
      got = {near_z_o, near_y_o, near_x_o};
      if (nearest_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, got[0], got[1], got[2]);
        errors++;
      end else begin
        want = nearest_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (want[i] !== got[i]) begin
            $display("%0t: near axis %0d expected %h actual %h", $time, i, want[i], got[i]);
            errors++;
          end
        end
      end
    end
  end

  localparam int ONE = 65536;
  localparam int MAXC = 32'h7fffffff;
  localparam int MINC = 32'h80000000;

  initial begin
    // Directed transactions: box from -1 to 1 on each axis unless noted.
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0});
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE});
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, -3*ONE, 0, 0, 3*ONE, 0, 0});
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, -3*ONE, 2*ONE, 0, 3*ONE, 2*ONE, 0});
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 3*ONE, 2*ONE, 4*ONE, -3*ONE, -2*ONE, 3*ONE});
    // Start exactly on the upper face, moving away and moving back in.
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, ONE, 0, 0, 3*ONE, ONE, 0});
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, ONE, 2*ONE, 0, -ONE, 2*ONE, 0});
    // Thin slab: zero-width box on x crossed by the segment.
    add('{0, -ONE, -ONE, 0, ONE, ONE, -2*ONE, 3*ONE, 0, 2*ONE, 3*ONE, ONE});
    add('{ONE, ONE, ONE, ONE, ONE, ONE, -4*ONE, -3*ONE, -2*ONE, 4*ONE, 5*ONE, 6*ONE});
    // Inverted box on one and on all axes.
    add('{ONE, -ONE, -ONE, -ONE, ONE, ONE, 3*ONE, 3*ONE, 0, -3*ONE, 4*ONE, 0});
    add('{ONE, ONE, ONE, -ONE, -ONE, -ONE, 2*ONE, -5*ONE, 7*ONE, -2*ONE, 5*ONE, 1});
    // Slope positive at the start, and no zero within the segment.
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 9*ONE, 8*ONE, 7*ONE});
    add('{-ONE, -ONE, -ONE, ONE, ONE, ONE, -9*ONE, -8*ONE, -7*ONE, -2*ONE, -3*ONE, -4*ONE});
    // Extremes of the coordinate range.
    add('{MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC});
    add('{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0, MINC, MAXC, 0});
    add('{MINC, MINC, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
    add('{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC}, 1'b1);
    add('{-1, -1, -1, 1, 1, 1, -1, 0, 1, 1, 0, -1});
    add('{-ONE, -2*ONE, -3*ONE, ONE, 2*ONE, 3*ONE, -5*ONE, -6*ONE, -7*ONE,
          6*ONE, 5*ONE, 9*ONE});
    for (int n = 0; n < 1600; n++) add_random(n == 400 || n == 1100);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (jobs.size() > 0 || start || nearest_q.size() > 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
    if (errors == 0) begin
      $display("segment_box_closest_point_top regression: pass");
    end else begin
      $display("segment_box_closest_point_top regression: fail");
    end
    $finish;
  end

  // Timeout that ends a hung run as a failure.
  initial begin
    #200ms;
    $display("segment_box_closest_point_top regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
sv/sbcp_pkg.sv
sv/sbcp_mul.sv
sv/sbcp_div.sv
sv/segment_box_closest_point_top.sv
sv/sbcp_checker.sv
test/tb_segment_box_closest_point_top.sv
